>>> hdl/dhs_pkg.sv
// Shared types and constants of the double hash set insert block.
package dhs_pkg;

  localparam int SLOT_W    = 10;
  localparam int PROBE_W   = 10;
  localparam int ICL_W     = 4;
  localparam int LF_W      = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int LF_FRAC_W = 8;

  localparam logic [ICL_W-1:0] ICL_RESET = 4'd4;
  localparam logic [LF_W-1:0]  LF_RESET  = 9'd192;
  localparam logic [LF_W-1:0]  LF_MAX    = 9'd256;
  localparam logic [LF_W-1:0]  LF_MIN    = 9'd1;

  localparam logic REG_ICL = 1'b0;
  localparam logic REG_LF  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [10:0] {
    ST_CLR   = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_CHECK = 11'b000_0000_0100,
    ST_GCLR  = 11'b000_0000_1000,
    ST_GRD   = 11'b000_0001_0000,
    ST_GRV   = 11'b000_0010_0000,
    ST_GPRD  = 11'b000_0100_0000,
    ST_GPCMP = 11'b000_1000_0000,
    ST_IPST  = 11'b001_0000_0000,
    ST_IPRD  = 11'b010_0000_0000,
    ST_IPCMP = 11'b100_0000_0000
  } dhs_state_e;

  typedef struct packed {
    logic start;
    logic step;
  } dhs_prb_cmd_t;

  // Low mask of a power-of-two table: 2^lg - 1.
  function automatic logic [31:0] lg_mask(input logic [7:0] lg);
    return (32'd1 << lg) - 32'd1;
  endfunction

endpackage

>>> hdl/double_hash_set_insert.sv
// Double hash set insert: top level with sequencer, two table banks and config port.
// Each probe of a key is a bank read and then a compare on the single bank port, and
// the finished result is then handed to the output register.
// Growth clears the new bank, then reads each old slot and probes to move each key. After
// reset and after each write of initial_capacity_log2 a clearing pass over all
// 2^MAX_CAPACITY_LOG2 slots of both banks runs with the input stalled.
module double_hash_set_insert #(
  parameter int MAX_CAPACITY_LOG2 = 10,
  parameter int KEY_WIDTH         = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [KEY_WIDTH-1:0]          key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dhs_pkg::SLOT_W-1:0]    slot_index_o,
  output logic [dhs_pkg::PROBE_W-1:0]   probe_count_o,
  output logic                          was_new_o,
  output logic                          grew_o,
  output logic                          status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhs_pkg::PADDR_W-1:0]   paddr,
  input  logic [dhs_pkg::PDATA_W-1:0]   pwdata,
  output logic [dhs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dhs_pkg::*;

  localparam int AW    = MAX_CAPACITY_LOG2;
  localparam int LW    = $clog2(MAX_CAPACITY_LOG2 + 2);
  localparam int DW    = KEY_WIDTH + 1;
  localparam int THR_W = LF_W + MAX_CAPACITY_LOG2;
  localparam logic [LW-1:0] LG_MAX = LW'(MAX_CAPACITY_LOG2);

  dhs_state_e state_q, state_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] mv_key_q, mv_key_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic                 active_q, active_d;
  logic [LW-1:0]        lg_q, lg_d;
  logic [AW:0]          occ_q, occ_d;
  logic                 grew_q, grew_d;
  logic [AW-1:0]        res_slot_q, res_slot_d;
  logic [AW-1:0]        res_idx_q, res_idx_d;
  logic                 res_new_q, res_new_d;
  logic                 res_st_q, res_st_d;
  logic                 fin_q, fin_d;
  logic                 out_valid_q;
  logic [AW-1:0]        out_slot_q, out_idx_q;
  logic                 out_new_q, out_grew_q, out_st_q;
  logic [ICL_W-1:0]     icl_q;
  logic [LF_W-1:0]      lf_q;

  logic          bank_we [2];
  logic [AW-1:0] bank_addr [2];
  logic [DW-1:0] bank_wd [2];
  logic [DW-1:0] bank_rd [2];

  dhs_prb_cmd_t         prb_cmd;
  logic [AW-1:0]        prb_home;
  logic [LW-1:0]        prb_lg;
  logic [AW-1:0]        prb_slot, prb_idx;
  logic                 prb_last;

  logic [DW-1:0]        src_rd, dst_rd;
  logic [AW-1:0]        old_mask, new_mask;
  logic [LF_W-1:0]      lf_c;
  logic [THR_W-1:0]     thr;
  logic                 need_grow;
  logic                 cfg_wr, out_free, in_acc;
  logic [LW-1:0]        icl_clamped, icl_reset_lg;

  function automatic logic [LW-1:0] clamp_lg(input logic [ICL_W-1:0] v);
    logic [LW:0] w;
    w = (LW+1)'(v);
    if (w < (LW+1)'(1)) return LW'(1);
    if (w > (LW+1)'(MAX_CAPACITY_LOG2)) return LG_MAX;
    return LW'(w);
  endfunction

  for (genvar b = 0; b < 2; b++) begin : g_bank
    dhs_bank #(.AW(AW), .DW(DW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .addr_i  (bank_addr[b]),
      .wdata_i (bank_wd[b]),
      .rdata_o (bank_rd[b])
    );
  end

  dhs_probe #(.AW(AW), .LW(LW)) u_probe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (prb_cmd),
    .home_i (prb_home),
    .lg_i   (prb_lg),
    .slot_o (prb_slot),
    .idx_o  (prb_idx),
    .last_o (prb_last)
  );

  assign cfg_wr       = psel && penable && pwrite && pready;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_LF) ? PDATA_W'(lf_q) : PDATA_W'(icl_q);
  assign icl_clamped  = clamp_lg(pwdata[ICL_W-1:0]);
  assign icl_reset_lg = clamp_lg(ICL_RESET);

  assign src_rd   = bank_rd[active_q];
  assign dst_rd   = bank_rd[~active_q];
  assign old_mask = AW'(lg_mask(8'(lg_q)));
  assign new_mask = AW'(lg_mask(8'(lg_q + LW'(1))));

  assign lf_c = (lf_q < LF_MIN) ? LF_MIN : ((lf_q > LF_MAX) ? LF_MAX : lf_q);
  assign thr  = (THR_W'(lf_c) << lg_q) >> LF_FRAC_W;
  assign need_grow = (THR_W'(occ_q) + THR_W'(2)) > thr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    mv_key_d   = mv_key_q;
    cnt_d      = cnt_q;
    active_d   = active_q;
    lg_d       = lg_q;
    occ_d      = occ_q;
    grew_d     = grew_q;
    res_slot_d = res_slot_q;
    res_idx_d  = res_idx_q;
    res_new_d  = res_new_q;
    res_st_d   = res_st_q;
    fin_d      = fin_q;
    prb_cmd    = '0;
    prb_home   = AW'(key_q);
    prb_lg     = lg_q;
    for (int b = 0; b < 2; b++) begin
      bank_we[b]   = 1'b0;
      bank_addr[b] = prb_slot;
      bank_wd[b]   = '0;
    end

    if (fin_q && out_free) begin
      fin_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        for (int b = 0; b < 2; b++) begin
          bank_we[b]   = 1'b1;
          bank_addr[b] = cnt_q;
        end
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          key_d   = key_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!fin_q) begin
          grew_d = 1'b0;
          if (need_grow) begin
            if (lg_q >= LG_MAX) begin
              res_slot_d = '0;
              res_idx_d  = '0;
              res_new_d  = 1'b0;
              res_st_d   = STATUS_FULL;
              fin_d      = 1'b1;
              state_d    = ST_IDLE;
            end else begin
              cnt_d   = '0;
              occ_d   = '0;
              state_d = ST_GCLR;
            end
          end else begin
            state_d = ST_IPST;
          end
        end
      end
      ST_GCLR: begin
        bank_we[~active_q]   = 1'b1;
        bank_addr[~active_q] = cnt_q;
        if (cnt_q == new_mask) begin
          cnt_d   = '0;
          state_d = ST_GRD;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_GRD: begin
        bank_addr[active_q] = cnt_q;
        state_d = ST_GRV;
      end
      ST_GRV: begin
        if (src_rd[DW-1]) begin
          mv_key_d      = src_rd[KEY_WIDTH-1:0];
          prb_cmd.start = 1'b1;
          prb_home      = AW'(src_rd[KEY_WIDTH-1:0]);
          prb_lg        = lg_q + LW'(1);
          state_d       = ST_GPRD;
        end else if (cnt_q == old_mask) begin
          active_d = ~active_q;
          lg_d     = lg_q + LW'(1);
          grew_d   = 1'b1;
          state_d  = ST_IPST;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          state_d = ST_GRD;
        end
      end
      ST_GPRD: begin
        state_d = ST_GPCMP;
      end
      ST_GPCMP: begin
        if (!dst_rd[DW-1] || dst_rd[KEY_WIDTH-1:0] == mv_key_q || prb_last) begin
          if (!dst_rd[DW-1] || dst_rd[KEY_WIDTH-1:0] == mv_key_q) begin
            bank_we[~active_q] = 1'b1;
            bank_wd[~active_q] = {1'b1, mv_key_q};
            if (!dst_rd[DW-1]) begin
              occ_d = occ_q + (AW+1)'(1);
            end
          end
          if (cnt_q == old_mask) begin
            active_d = ~active_q;
            lg_d     = lg_q + LW'(1);
            grew_d   = 1'b1;
            state_d  = ST_IPST;
          end else begin
            cnt_d   = cnt_q + AW'(1);
            state_d = ST_GRD;
          end
        end else begin
          prb_cmd.step = 1'b1;
          state_d      = ST_GPRD;
        end
      end
      ST_IPST: begin
        prb_cmd.start = 1'b1;
        state_d       = ST_IPRD;
      end
      ST_IPRD: begin
        state_d = ST_IPCMP;
      end
      ST_IPCMP: begin
        if (!src_rd[DW-1] || src_rd[KEY_WIDTH-1:0] == key_q) begin
          bank_we[active_q] = 1'b1;
          bank_wd[active_q] = {1'b1, key_q};
          if (!src_rd[DW-1]) begin
            occ_d = occ_q + (AW+1)'(1);
          end
          res_slot_d = prb_slot;
          res_idx_d  = prb_idx;
          res_new_d  = !src_rd[DW-1];
          res_st_d   = STATUS_OK;
          fin_d      = 1'b1;
          state_d    = ST_IDLE;
        end else if (prb_last) begin
          res_slot_d = '0;
          res_idx_d  = '0;
          res_new_d  = 1'b0;
          res_st_d   = STATUS_FULL;
          fin_d      = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          prb_cmd.step = 1'b1;
          state_d      = ST_IPRD;
        end
      end
      default: begin
        state_d = ST_CLR;
        cnt_d   = '0;
      end
    endcase
  end

  // fin_q marks a finished result waiting for the output register; the idle
  // state may take the next key meanwhile, which then waits in the check state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      cnt_q    <= '0;
      active_q <= 1'b0;
      lg_q     <= icl_reset_lg;
      occ_q    <= '0;
      grew_q   <= 1'b0;
      fin_q    <= 1'b0;
      icl_q    <= ICL_RESET;
      lf_q     <= LF_RESET;
    end else if (cfg_wr && paddr[2] == REG_ICL) begin
      icl_q    <= pwdata[ICL_W-1:0];
      state_q  <= ST_CLR;
      cnt_q    <= '0;
      active_q <= 1'b0;
      lg_q     <= icl_clamped;
      occ_q    <= '0;
      grew_q   <= grew_d;
      fin_q    <= fin_d;
    end else begin
      if (cfg_wr) begin
        lf_q <= pwdata[LF_W-1:0];
      end
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
      lg_q     <= lg_d;
      occ_q    <= occ_d;
      grew_q   <= grew_d;
      fin_q    <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    mv_key_q   <= mv_key_d;
    res_slot_q <= res_slot_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_st_q   <= res_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q && out_free) begin
      out_slot_q <= res_slot_q;
      out_idx_q  <= res_idx_q;
      out_new_q  <= res_new_q;
      out_grew_q <= grew_q;
      out_st_q   <= res_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_index_o  = SLOT_W'(out_slot_q);
  assign probe_count_o = PROBE_W'(out_idx_q);
  assign was_new_o     = out_new_q;
  assign grew_o        = out_grew_q;
  assign status_o      = out_st_q;

endmodule

>>> hdl/dhs_bank.sv
// Single-port table bank with registered read data.
module dhs_bank #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dhs_probe.sv
// Shared probe address generator: home slot, odd stride and probe index.
module dhs_probe #(
  parameter int AW = 10,
  parameter int LW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhs_pkg::dhs_prb_cmd_t cmd_i,
  input  logic [AW-1:0]         home_i,
  input  logic [LW-1:0]         lg_i,
  output logic [AW-1:0]         slot_o,
  output logic [AW-1:0]         idx_o,
  output logic                  last_o
);
  import dhs_pkg::*;

  logic [AW-1:0] slot_q, slot_d;
  logic [AW-1:0] stride_q, stride_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] mask_q, mask_d;
  logic [AW-1:0] mask_new;
  logic [AW-1:0] home_m;

  assign mask_new = AW'(lg_mask(8'(lg_i)));
  assign home_m   = home_i & mask_new;

  always_comb begin
    slot_d   = slot_q;
    stride_d = stride_q;
    idx_d    = idx_q;
    mask_d   = mask_q;
    if (cmd_i.start) begin
      slot_d   = home_m;
      stride_d = ((AW'(1) - home_m) | AW'(1)) & mask_new;
      idx_d    = '0;
      mask_d   = mask_new;
    end else if (cmd_i.step) begin
      slot_d = (slot_q + stride_q) & mask_q;
      idx_d  = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      stride_q <= '0;
      idx_q    <= '0;
      mask_q   <= '0;
    end else begin
      slot_q   <= slot_d;
      stride_q <= stride_d;
      idx_q    <= idx_d;
      mask_q   <= mask_d;
    end
  end

  assign slot_o = slot_q;
  assign idx_o  = idx_q;
  assign last_o = (idx_q == mask_q);

endmodule

>>> hdl/dhs_checker.sv
// Port-level checker for the double hash set insert block, with its bind.
module dhs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [dhs_pkg::SLOT_W-1:0]  slot_index_o,
  input logic [dhs_pkg::PROBE_W-1:0] probe_count_o,
  input logic                        was_new_o,
  input logic                        status_o
);
  import dhs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_index_o) && $stable(status_o))
    else $error("stalled item changed");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |->
      slot_index_o == '0 && probe_count_o == '0 && !was_new_o)
    else $error("rejected item carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("ready right after an accepted item");

  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input ready during clearing pass");

endmodule

bind double_hash_set_insert dhs_checker u_dhs_checker (.*);

>>> dv/tb_double_hash_set_insert.sv
// Testbench for the double hash set insert block: directed table, random keys, scoreboard.
`timescale 1ns / 1ps

module tb_double_hash_set_insert;
  import dhs_pkg::*;

  localparam int MAXLG = 10;
  localparam int KW    = 31;
  localparam int NSLOT = 1 << MAXLG;
  localparam int WDOG  = 2000000;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [PROBE_W-1:0] probes;
    logic               is_new;
    logic               grew;
    logic               status;
  } ins_res_t;

  typedef struct {
    logic [KW-1:0] key;
    logic          chk;
    ins_res_t      res;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [KW-1:0] key_i = '0;
  logic in_stall_o, out_valid_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic [PROBE_W-1:0] probe_count_o;
  logic was_new_o, grew_o, status_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  double_hash_set_insert dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // predictor state
  logic          tbl_vld [2][NSLOT];
  logic [KW-1:0] tbl_key [2][NSLOT];
  int            act_bank, cur_lg, occ, icl_reg, lf_reg;

  ins_res_t expected_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet_tail = 0;
  bit  hold_off = 0;

  function automatic bit find_slot(int b, int lg, logic [KW-1:0] k,
                                   output int slot, output int steps);
    int cap, home, stride, s;
    cap = 1 << lg;
    home = k & (cap - 1);
    stride = cap + 1 - home;
    if (stride % 2 == 0) stride++;
    for (int i = 0; i < cap; i++) begin
      s = (home + stride * i) & (cap - 1);
      if (!tbl_vld[b][s] || tbl_key[b][s] == k) begin
        slot = s;
        steps = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void set_clear();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_vld[0][i] = 0;
      tbl_vld[1][i] = 0;
    end
    act_bank = 0;
    occ = 0;
    cur_lg = (icl_reg < 1) ? 1 : (icl_reg > MAXLG ? MAXLG : icl_reg);
  endfunction

  function automatic void grow_table();
    int d, s, n;
    d = act_bank ^ 1;
    for (int i = 0; i < NSLOT; i++) tbl_vld[d][i] = 0;
    occ = 0;
    for (int i = 0; i < (1 << cur_lg); i++)
      if (tbl_vld[act_bank][i] && find_slot(d, cur_lg + 1, tbl_key[act_bank][i], s, n)) begin
        if (!tbl_vld[d][s]) occ++;
        tbl_vld[d][s] = 1;
        tbl_key[d][s] = tbl_key[act_bank][i];
      end
    cur_lg++;
    act_bank = d;
  endfunction

  function automatic ins_res_t predict_insert(logic [KW-1:0] k);
    ins_res_t r;
    int lf, thr, s, n;
    r = '0;
    r.status = STATUS_FULL;
    lf = (lf_reg < 1) ? 1 : (lf_reg > 256 ? 256 : lf_reg);
    thr = ((1 << cur_lg) * lf) >> 8;
    if (occ + 2 > thr) begin
      if (cur_lg >= MAXLG) return r;
      grow_table();
      r.grew = 1;
    end
    if (!find_slot(act_bank, cur_lg, k, s, n)) return r;
    if (!tbl_vld[act_bank][s]) begin
      occ++;
      r.is_new = 1;
    end
    tbl_vld[act_bank][s] = 1;
    tbl_key[act_bank][s] = k;
    r.slot = s;
    r.probes = n;
    r.status = STATUS_OK;
    return r;
  endfunction

  task automatic apb_write(logic [PADDR_W-1:0] addr, int val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == PADDR_W'(REG_ICL * 4)) begin
      icl_reg = val & 4'hf;
      set_clear();
    end else lf_reg = val & 9'h1ff;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_key(logic [KW-1:0] k, bit chk, ins_res_t want);
    ins_res_t r;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    key_i <= k;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_insert(k);
    if (chk && r != want) begin
      $error("table row disagrees with predictor for key %0d", k);
      errors++;
    end
    expected_q.push_back(r);
  endtask

  // result checking
  always @(posedge clk_i) begin
    ins_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (slot_index_o !== e.slot) begin
          $error("slot_index exp %0d got %0d", e.slot, slot_index_o); errors++;
        end
        if (probe_count_o !== e.probes) begin
          $error("probe_count exp %0d got %0d", e.probes, probe_count_o); errors++;
        end
        if (was_new_o !== e.is_new) begin
          $error("was_new exp %0d got %0d", e.is_new, was_new_o); errors++;
        end
        if (grew_o !== e.grew) begin
          $error("grew exp %0d got %0d", e.grew, grew_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
        out_stall_i <= 0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    ins_res_t z;
    int lgs[5] = '{1, 10, 0, 3, 15};
    int lfs[5] = '{256, 1, 0, 511, 128};
    logic [KW-1:0] k;
    icl_reg = ICL_RESET;
    lf_reg = LF_RESET;
    set_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: fresh 16-slot set, lf 192
    z = '0; z.is_new = 1;
    rows.push_back('{31'd0, 1'b1, z});
    rows.push_back('{31'd0, 1'b0, z});
    rows.push_back('{31'h7fffffff, 1'b0, z});
    rows.push_back('{31'd16, 1'b0, z});
    rows.push_back('{31'd32, 1'b0, z});
    rows.push_back('{31'h55555555, 1'b0, z});
    rows.push_back('{31'h2aaaaaaa, 1'b0, z});
    for (int i = 0; i < 14; i++) rows.push_back('{KW'(i * 7 + 1), 1'b0, z});
    foreach (rows[i]) send_key(rows[i].key, rows[i].chk, rows[i].res);
    drain();

    // max capacity refusal: lg 10, lf 1 -> threshold 4, three keys fit
    apb_write(PADDR_W'(REG_LF * 4), 1);
    apb_write(PADDR_W'(REG_ICL * 4), 10);
    z = '0;
    send_key(31'd1, 0, z);
    send_key(31'd2, 0, z);
    send_key(31'd3, 0, z);
    z.status = STATUS_FULL;
    send_key(31'd5, 1, z);
    send_key(31'h7fffffff, 1, z);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      apb_write(PADDR_W'(REG_LF * 4), lfs[ph]);
      apb_write(PADDR_W'(REG_ICL * 4), lgs[ph]);
      for (int n = 0; n < 300; n++) begin
        if (ph == 3 && n == 20) hold_off = 1;
        case ($urandom_range(0, 3))
          0: k = KW'($urandom);
          1: k = KW'($urandom_range(0, 63));
          2: k = {$urandom_range(0, 1) ? 21'h1fffff : 21'h0, 10'($urandom)};
          default: k = KW'($urandom_range(0, 4000));
        endcase
        if (ph == 4 && n >= 200) quiet_tail = 1;
        send_key(k, 0, z);
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
